// ===== rtl/core/wsd_pkg.sv =====
`default_nettype none
package wsd_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  // parse phases
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // header opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // message types
  localparam logic [2:0] MT_CONT   = 3'd0;
  localparam logic [2:0] MT_TEXT   = 3'd1;
  localparam logic [2:0] MT_BINARY = 3'd2;
  localparam logic [2:0] MT_PING   = 3'd3;
  localparam logic [2:0] MT_PONG   = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_OPCODE  = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  // 7-bit length escapes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // configuration register indexes
  localparam logic CFG_IDX_MASK   = 1'b0;
  localparam logic CFG_IDX_MAXLEN = 1'b1;

  localparam logic [31:0] MAX_LEN_RST = 32'd65536;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [2:0] message_type;
    logic       final_fragment;
    logic       frame_end;
    logic [1:0] error_code;
  } wsd_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/wsd_parser.sv =====
`default_nettype none
module wsd_parser import wsd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        byte_fire,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_mask_key,
  input  wire logic [31:0] cfg_max_len,
  output logic             res_vld,
  output wsd_res_t         res
);

  localparam int CMP_W = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;

  logic [2:0]             phase_r, phase_nxt;
  logic                   halted_r, halted_nxt;
  logic                   fin_r, fin_nxt;
  logic [2:0]             type_r, type_nxt;
  logic [3:0]             ext_r, ext_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [COUNT_WIDTH-1:0] remain_r, remain_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [31:0]            acc_r, acc_nxt;

  logic [COUNT_WIDTH-1:0] len_n;
  logic                   ovf_n;
  logic                   len_done;
  logic [CMP_W-1:0]       len_x;
  logic [31:0]            diff;
  logic                   too_long;
  logic [7:0]             key_byte;
  logic                   emit;
  logic [7:0]             e_data;
  logic                   e_has;
  logic                   e_end;
  logic [1:0]             e_err;

  assign len_x    = CMP_W'(len_n);
  assign diff     = cfg_max_len - acc_r;
  assign too_long = ovf_n || (acc_r > cfg_max_len) || (len_x > CMP_W'(diff));
  assign key_byte = key_r[{~idx_r, 3'b000} +: 8];

  always_comb begin
    phase_nxt  = phase_r;
    halted_nxt = halted_r;
    fin_nxt    = fin_r;
    type_nxt   = type_r;
    ext_nxt    = ext_r;
    ovf_nxt    = ovf_r;
    remain_nxt = remain_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    len_n      = remain_r;
    ovf_n      = ovf_r;
    len_done   = 1'b0;
    emit       = 1'b0;
    e_data     = 8'd0;
    e_has      = 1'b0;
    e_end      = 1'b0;
    e_err      = ERR_NONE;

    if (byte_fire && !halted_r) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt   = rx_byte[7];
          phase_nxt = PH_HDR1;
          case (rx_byte[3:0])
            OP_CONT:   type_nxt = MT_CONT;
            OP_TEXT:   type_nxt = MT_TEXT;
            OP_BINARY: type_nxt = MT_BINARY;
            OP_PING:   type_nxt = MT_PING;
            OP_PONG:   type_nxt = MT_PONG;
            default: begin
              // close and unknown opcodes stop the parser
              type_nxt   = MT_CONT;
              halted_nxt = 1'b1;
              phase_nxt  = phase_r;
              emit       = 1'b1;
              e_err      = ERR_OPCODE;
            end
          endcase
        end
        PH_HDR1: begin
          ovf_nxt    = 1'b0;
          ovf_n      = 1'b0;
          remain_nxt = '0;
          len_n      = COUNT_WIDTH'(rx_byte[6:0]);
          if (rx_byte[6:0] == LEN_EXT16) begin
            ext_nxt   = EXT16_BYTES;
            phase_nxt = PH_EXTLEN;
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            ext_nxt   = EXT64_BYTES;
            phase_nxt = PH_EXTLEN;
          end else begin
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          // bits shifted out past the counter width mark the length as too big
          ovf_n      = ovf_r | (remain_r[COUNT_WIDTH-1 -: 8] != 8'd0);
          len_n      = {remain_r[COUNT_WIDTH-9:0], rx_byte};
          remain_nxt = len_n;
          ovf_nxt    = ovf_n;
          ext_nxt    = ext_r - 4'd1;
          if (ext_r == 4'd1) len_done = 1'b1;
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          ext_nxt = ext_r - 4'd1;
          if (ext_r == 4'd1) begin
            idx_nxt = 2'd0;
            if (remain_r == '0) begin
              phase_nxt = PH_HDR0;
              emit      = 1'b1;
              e_end     = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          idx_nxt    = idx_r + 2'd1;
          remain_nxt = remain_r - COUNT_WIDTH'(1);
          emit       = 1'b1;
          e_has      = 1'b1;
          e_data     = rx_byte ^ key_byte;
          if (remain_r == COUNT_WIDTH'(1)) begin
            e_end     = 1'b1;
            phase_nxt = PH_HDR0;
          end
        end
        default: phase_nxt = PH_HDR0;
      endcase

      if (len_done) begin
        remain_nxt = len_n;
        ovf_nxt    = ovf_n;
        if (too_long) begin
          halted_nxt = 1'b1;
          emit       = 1'b1;
          e_err      = ERR_TOO_LONG;
        end else begin
          acc_nxt = fin_r ? 32'd0 : acc_r + len_x[31:0];
          key_nxt = 32'd0;
          idx_nxt = 2'd0;
          if (cfg_mask_key) begin
            ext_nxt   = KEY_BYTES;
            phase_nxt = PH_MASK;
          end else if (len_n == '0) begin
            phase_nxt = PH_HDR0;
            emit      = 1'b1;
            e_end     = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
    end

    res_vld            = emit;
    res.data_byte      = e_data;
    res.has_data       = e_has;
    res.message_type   = type_nxt;
    res.final_fragment = fin_nxt;
    res.frame_end      = e_end;
    res.error_code     = e_err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      halted_r <= 1'b0;
      fin_r    <= 1'b0;
      type_r   <= MT_CONT;
      ext_r    <= 4'd0;
      ovf_r    <= 1'b0;
      remain_r <= '0;
      key_r    <= 32'd0;
      idx_r    <= 2'd0;
      acc_r    <= 32'd0;
    end else begin
      phase_r  <= phase_nxt;
      halted_r <= halted_nxt;
      fin_r    <= fin_nxt;
      type_r   <= type_nxt;
      ext_r    <= ext_nxt;
      ovf_r    <= ovf_nxt;
      remain_r <= remain_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      acc_r    <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wsd_out_reg.sv =====
`default_nettype none
module wsd_out_reg import wsd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire wsd_res_t load_res,
  output logic          can_load,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output logic [7:0]    out_tdata,
  output logic [6:0]    out_tuser,
  output logic          out_tlast
);

  logic     vld_r, vld_nxt;
  wsd_res_t res_r;

  // the register frees up in the same cycle its transfer completes
  assign can_load = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (can_load) vld_nxt = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) res_r <= load_res;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = res_r.data_byte;
  assign out_tuser  = {res_r.error_code, res_r.final_fragment, res_r.message_type,
                       res_r.has_data};
  assign out_tlast  = res_r.frame_end;

endmodule
`default_nettype wire

// ===== rtl/core/websocket_frame_deframer_core.sv =====
`default_nettype none
// channel  direction  ports                        contents
// in       slave      in_tvalid/tready/tdata       one received frame byte
// out      master     out_tvalid/tready/tdata/...  one payload byte, marker or error
// cfg      write      cfg_we/addr/wdata            mask-key mode, message length limit
//
// one byte per cycle while in_tready is high; each byte is handled by the header/counter logic in the
// cycle it transfers and its result lands in the output register
// header, length and mask key bytes give an output transfer only for an error or the end of an empty frame
// rst_n is synchronous; the parser restarts at the first header byte
// in_tready drops only while the output register holds a result not yet taken
module websocket_frame_deframer_core import wsd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // data_byte
  output logic [6:0]       out_tuser,  // has_data, message_type[2:0], final_fragment,
                                       // error_code[1:0]
  output logic             out_tlast,  // frame_end
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  logic        mask_key_r;
  logic [31:0] max_len_r;
  logic        can_load;
  logic        byte_fire;
  logic        res_vld;
  wsd_res_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_key_r <= 1'b0;
      max_len_r  <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IDX_MASK:   mask_key_r <= cfg_wdata[0];
        CFG_IDX_MAXLEN: max_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = can_load;
  assign byte_fire = in_tvalid && in_tready;

  wsd_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_fire    (byte_fire),
    .rx_byte      (in_tdata),
    .cfg_mask_key (mask_key_r),
    .cfg_max_len  (max_len_r),
    .res_vld      (res_vld),
    .res          (res)
  );

  wsd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_vld),
    .load_res   (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
